// ===== sv/spbu_pkg.sv =====
`timescale 1ns / 1ps
package spbu_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FIELD_W         = 32;
	localparam int LEN_W           = 31;
	localparam int CNT_W           = 8;
	// signed dividend: covers 2 * (diff - offset * count) + length
	localparam int NUM_W           = 44;
	// divisor: up to twice a box length
	localparam int DEN_W           = 33;
	localparam int MB_W            = 32;
	localparam int PROD_W          = CNT_W + MB_W + 1;
	// working width of result components before saturation
	localparam int RES_W           = 50;
	localparam int CFG_IDX_W       = 3;

	localparam logic [1:0] MODE_DIFF = 2'd0;
	localparam logic [1:0] MODE_VEL  = 2'd1;
	localparam logic [1:0] MODE_WRAP = 2'd2;
	localparam logic [1:0] MODE_TICK = 2'd3;

	localparam logic [1:0] KIND_OPEN     = 2'd0;
	localparam logic [1:0] KIND_PERIODIC = 2'd1;
	localparam logic [1:0] KIND_SHEARED  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_KIND     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_Z    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SHEAR    = 3'd7;

	typedef struct packed {
		logic [1:0]                mode;
		logic signed [FIELD_W-1:0] a_x;
		logic signed [FIELD_W-1:0] a_y;
		logic signed [FIELD_W-1:0] a_z;
		logic signed [FIELD_W-1:0] b_x;
		logic signed [FIELD_W-1:0] b_y;
		logic signed [FIELD_W-1:0] b_z;
	} in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic signed [FIELD_W-1:0] out_z;
		logic signed [CNT_W-1:0]   image_shift_y;
	} out_t;

	function automatic logic signed [CNT_W-1:0] sat8(input logic signed [NUM_W-1:0] v);
		logic signed [NUM_W-1:0] hi;
		logic signed [NUM_W-1:0] lo;
		hi = NUM_W'(127);
		lo = -NUM_W'(128);
		if (v > hi) begin
			sat8 = hi[CNT_W-1:0];
		end else if (v < lo) begin
			sat8 = lo[CNT_W-1:0];
		end else begin
			sat8 = v[CNT_W-1:0];
		end
	endfunction

endpackage

// ===== sv/spbu_div.sv =====
`timescale 1ns / 1ps
// restoring divider, one dividend bit per cycle, floor quotient, nonnegative remainder
module spbu_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [spbu_pkg::NUM_W-1:0]   num,
	input  logic        [spbu_pkg::DEN_W-1:0]   den,
	output logic                                busy,
	output logic                                done,
	output logic signed [spbu_pkg::NUM_W-1:0]   quo,
	output logic        [spbu_pkg::DEN_W-1:0]   rem
);
	localparam int NW = spbu_pkg::NUM_W;
	localparam int DW = spbu_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(NW);
	localparam logic [CW-1:0] CNT_LAST = CW'(1);

	logic          busy_q, done_q, neg_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] sh_q;
	logic [DW-1:0] rem_q, den_q;
	logic [DW:0]   trial, diff;
	logic          ge, nz;

	always_comb begin
		trial = {rem_q, sh_q[NW-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
		nz    = rem_q != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_FULL;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NW-1];
			sh_q  <= num[NW-1] ? NW'(-num) : NW'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			sh_q  <= {sh_q[NW-2:0], ge};
		end
	end

	// negative dividend: fold magnitude result back to floor form
	assign quo  = neg_q ? (nz ? $signed(~sh_q) : $signed(-sh_q)) : $signed(sh_q);
	assign rem  = (neg_q && nz) ? den_q - rem_q : rem_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== sv/spbu_mul.sv =====
`timescale 1ns / 1ps
// serial shift-add multiplier: signed count times unsigned length or shear offset, one count bit per cycle
module spbu_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [spbu_pkg::CNT_W-1:0]    a,
	input  logic        [spbu_pkg::MB_W-1:0]     b,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [spbu_pkg::PROD_W-1:0]   prod
);
	localparam int AW = spbu_pkg::CNT_W;
	localparam int PW = spbu_pkg::PROD_W;
	localparam int IW = $clog2(AW);
	localparam logic [IW-1:0] IDX_LAST = IW'(AW - 1);

	logic                 busy_q, done_q;
	logic [IW-1:0]        idx_q;
	logic [AW-1:0]        a_q;
	logic signed [PW-1:0] b_q, acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + IW'(1);
				if (idx_q == IDX_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= $signed({{(PW - spbu_pkg::MB_W){1'b0}}, b});
			acc_q <= '0;
		end else if (busy_q) begin
			// sign bit of the count carries negative weight
			if (a_q[0]) begin
				acc_q <= (idx_q == IDX_LAST) ? acc_q - b_q : acc_q + b_q;
			end
			a_q <= a_q >> 1;
			b_q <= b_q <<< 1;
		end
	end

	assign prod = acc_q;
	assign busy = busy_q;
	assign done = done_q;

endmodule

// ===== sv/sheared_periodic_boundary_unit.sv =====
`timescale 1ns / 1ps
// Open kind or velocity difference go straight to the result; sheared velocity runs one
// multiply; tick one divide; periodic position/wrap three divides, sheared also two multiplies.
// Throughput: one transaction at a time; the serial divider (one dividend bit per cycle)
// run three times per periodic request sets the rate.
// Reset (arst_n low, async): registers back to defaults, shear offset and stored count zero.
module sheared_periodic_boundary_unit #(
	parameter int COORD_WIDTH = spbu_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  spbu_pkg::in_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output spbu_pkg::out_t                     out_data,
	input  logic                               cfg_we,
	input  logic [spbu_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [spbu_pkg::FIELD_W-1:0]       cfg_wdata
);
	localparam int RW = spbu_pkg::RES_W;
	localparam int NW = spbu_pkg::NUM_W;
	localparam int DW = spbu_pkg::DEN_W;
	localparam int LW = spbu_pkg::LEN_W;
	localparam int FW = spbu_pkg::FIELD_W;
	localparam int KW = spbu_pkg::CNT_W;
	localparam int PW = spbu_pkg::PROD_W;

	localparam logic signed [RW-1:0] C_HI = RW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
	localparam logic signed [RW-1:0] C_LO = -C_HI - RW'(1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_YDIV = 4'd1;
	localparam logic [3:0] S_XMUL = 4'd2;
	localparam logic [3:0] S_XDIV = 4'd3;
	localparam logic [3:0] S_YMUL = 4'd4;
	localparam logic [3:0] S_ZDIV = 4'd5;
	localparam logic [3:0] S_TDIV = 4'd6;
	localparam logic [3:0] S_VMUL = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	function automatic logic signed [RW-1:0] ext(input logic signed [FW-1:0] f);
		ext = {{(RW - FW){f[FW-1]}}, f};
	endfunction

	function automatic logic signed [FW-1:0] sat_coord(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] t;
		t = v;
		if (t > C_HI) begin
			t = C_HI;
		end
		if (t < C_LO) begin
			t = C_LO;
		end
		sat_coord = t[FW-1:0];
	endfunction

	// configuration
	logic [1:0]           kind_reg_q;
	logic [LW-1:0]        box_x_q, box_y_q, box_z_q, shear_step_q;
	logic signed [FW-1:0] org_x_q, org_y_q, org_z_q;

	// persistent state
	logic [FW-1:0]        shear_off_q;
	logic signed [KW-1:0] last_shift_q;

	// sequencer and datapath
	logic [3:0]           state_q;
	logic                 run_q;
	logic [1:0]           mode_q, kind_q;
	logic signed [RW-1:0] x_q, y_q, z_q;
	logic signed [KW-1:0] cnt_q, c_q;
	logic                 out_valid_q;
	spbu_pkg::out_t       out_q;

	logic [LW-1:0]        lx, ly, lz, len_sel;
	logic signed [FW-1:0] org_sel;
	logic signed [RW-1:0] v_sel, len_ext, org_ext, rem_ext, num_wide, axis_res, near_t;
	logic                 near;
	logic                 div_start, div_busy, div_done;
	logic signed [NW-1:0] div_num, div_quo;
	logic [DW-1:0]        div_den, div_rem;
	logic                 mul_start, mul_busy, mul_done;
	logic signed [KW-1:0] mul_a;
	logic [spbu_pkg::MB_W-1:0] mul_b;
	logic signed [PW-1:0] mul_prod;
	logic signed [RW-1:0] prod_ext;
	logic signed [KW-1:0] q_sat;
	logic                 is_div_st, is_mul_st, sheared;

	// zero box length acts as one
	assign lx = (box_x_q == '0) ? LW'(1) : box_x_q;
	assign ly = (box_y_q == '0) ? LW'(1) : box_y_q;
	assign lz = (box_z_q == '0) ? LW'(1) : box_z_q;

	assign sheared   = kind_q == spbu_pkg::KIND_SHEARED;
	assign near      = mode_q == spbu_pkg::MODE_DIFF;
	assign is_div_st = (state_q == S_YDIV) || (state_q == S_XDIV) ||
	                   (state_q == S_ZDIV) || (state_q == S_TDIV);
	assign is_mul_st = (state_q == S_XMUL) || (state_q == S_YMUL) || (state_q == S_VMUL);
	assign div_start = is_div_st && !run_q;
	assign mul_start = is_mul_st && !run_q;

	// axis operands for the divider
	always_comb begin
		case (state_q)
			S_YDIV: begin
				v_sel   = y_q;
				len_sel = ly;
				org_sel = org_y_q;
			end
			S_XDIV: begin
				v_sel   = x_q;
				len_sel = lx;
				org_sel = org_x_q;
			end
			default: begin
				v_sel   = z_q;
				len_sel = lz;
				org_sel = org_z_q;
			end
		endcase
		len_ext = $signed({{(RW - LW){1'b0}}, len_sel});
		org_ext = ext(org_sel);
		rem_ext = $signed({{(RW - DW){1'b0}}, div_rem});
		if (state_q == S_TDIV) begin
			num_wide = $signed({{(RW - FW){1'b0}}, shear_off_q}) +
			           $signed({{(RW - LW){1'b0}}, shear_step_q});
			div_den  = {{(DW - LW){1'b0}}, lx};
		end else if (near) begin
			// nearest image: floor((2r + L) / 2L)
			num_wide = (v_sel <<< 1) + len_ext;
			div_den  = {{(DW - LW - 1){1'b0}}, len_sel, 1'b0};
		end else begin
			num_wide = v_sel - org_ext;
			div_den  = {{(DW - LW){1'b0}}, len_sel};
		end
		div_num = num_wide[NW-1:0];
		// r - q*L from the remainder alone: (m - L) / 2, or origin + m for wrap
		near_t   = rem_ext - len_ext;
		axis_res = near ? (near_t >>> 1) : (org_ext + rem_ext);
		q_sat    = spbu_pkg::sat8(div_quo);
	end

	// multiplier operands
	always_comb begin
		case (state_q)
			S_XMUL: begin
				mul_a = c_q;
				mul_b = shear_off_q;
			end
			S_VMUL: begin
				mul_a = last_shift_q;
				mul_b = {1'b0, ly};
			end
			default: begin
				mul_a = c_q;
				mul_b = {1'b0, ly};
			end
		endcase
		prod_ext = {{(RW - PW){mul_prod[PW-1]}}, mul_prod};
	end

	spbu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	spbu_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// control and persistent state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_reg_q   <= spbu_pkg::KIND_OPEN;
			box_x_q      <= LW'(1048576);
			box_y_q      <= LW'(1048576);
			box_z_q      <= LW'(1048576);
			org_x_q      <= '0;
			org_y_q      <= '0;
			org_z_q      <= '0;
			shear_step_q <= '0;
			shear_off_q  <= '0;
			last_shift_q <= '0;
			state_q      <= S_IDLE;
			run_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					spbu_pkg::REG_KIND:     kind_reg_q   <= cfg_wdata[1:0];
					spbu_pkg::REG_BOX_X:    box_x_q      <= cfg_wdata[LW-1:0];
					spbu_pkg::REG_BOX_Y:    box_y_q      <= cfg_wdata[LW-1:0];
					spbu_pkg::REG_BOX_Z:    box_z_q      <= cfg_wdata[LW-1:0];
					spbu_pkg::REG_ORIGIN_X: org_x_q      <= $signed(cfg_wdata);
					spbu_pkg::REG_ORIGIN_Y: org_y_q      <= $signed(cfg_wdata);
					spbu_pkg::REG_ORIGIN_Z: org_z_q      <= $signed(cfg_wdata);
					spbu_pkg::REG_SHEAR:    shear_step_q <= cfg_wdata[LW-1:0];
					default: ;
				endcase
			end

			if (div_start || mul_start) begin
				run_q <= 1'b1;
			end else if (div_done || mul_done) begin
				run_q <= 1'b0;
			end

			// load a new result, or drop the one just taken
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_data.mode)
							spbu_pkg::MODE_TICK: state_q <= S_TDIV;
							spbu_pkg::MODE_VEL: begin
								state_q <= (kind_reg_q == spbu_pkg::KIND_SHEARED) ?
								           S_VMUL : S_DONE;
							end
							default: begin
								state_q <= (kind_reg_q == spbu_pkg::KIND_PERIODIC ||
								            kind_reg_q == spbu_pkg::KIND_SHEARED) ?
								           S_YDIV : S_DONE;
							end
						endcase
					end
				end
				S_YDIV: begin
					if (div_done) begin
						state_q <= sheared ? S_XMUL : S_XDIV;
						if (sheared && near) begin
							last_shift_q <= q_sat;
						end
					end
				end
				S_XMUL: if (mul_done) state_q <= S_XDIV;
				S_XDIV: if (div_done) state_q <= sheared ? S_YMUL : S_ZDIV;
				S_YMUL: if (mul_done) state_q <= S_ZDIV;
				S_ZDIV: if (div_done) state_q <= S_DONE;
				S_TDIV: begin
					if (div_done) begin
						shear_off_q <= div_rem[FW-1:0];
						state_q     <= S_DONE;
					end
				end
				S_VMUL: if (mul_done) state_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					mode_q <= in_data.mode;
					kind_q <= (kind_reg_q == spbu_pkg::KIND_SHEARED ||
					           kind_reg_q == spbu_pkg::KIND_PERIODIC) ?
					          kind_reg_q : spbu_pkg::KIND_OPEN;
					cnt_q  <= '0;
					case (in_data.mode)
						spbu_pkg::MODE_WRAP: begin
							x_q <= ext(in_data.a_x);
							y_q <= ext(in_data.a_y);
							z_q <= ext(in_data.a_z);
						end
						spbu_pkg::MODE_TICK: begin
							x_q <= '0;
							y_q <= '0;
							z_q <= '0;
						end
						default: begin
							x_q <= ext(in_data.b_x) - ext(in_data.a_x);
							y_q <= ext(in_data.b_y) - ext(in_data.a_y);
							z_q <= ext(in_data.b_z) - ext(in_data.a_z);
						end
					endcase
				end
			end
			S_YDIV: begin
				if (div_done) begin
					cnt_q <= q_sat;
					c_q   <= q_sat;
					// plain periodic keeps the full count in the remainder
					if (!sheared) begin
						y_q <= axis_res;
					end
				end
			end
			S_XMUL: if (mul_done) x_q <= x_q - prod_ext;
			S_XDIV: if (div_done) x_q <= axis_res;
			S_YMUL: if (mul_done) y_q <= y_q - prod_ext;
			S_ZDIV: if (div_done) z_q <= axis_res;
			S_VMUL: begin
				if (mul_done) begin
					x_q   <= x_q - prod_ext;
					cnt_q <= last_shift_q;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_q.out_x         <= sat_coord(x_q);
					out_q.out_y         <= sat_coord(y_q);
					out_q.out_z         <= sat_coord(z_q);
					out_q.image_shift_y <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("accepted transaction did not raise stall");

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy && mul_busy))
		else $error("divider and multiplier active together");

	a_offset_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(shear_off_q) |-> $past(state_q == S_TDIV))
		else $error("shear offset changed outside a tick");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

	// Expected-result store and minimum-image predictor state
	class image_scoreboard;
		spbu_pkg::out_t pending[$];
		int    n_errors;
		int    n_checked;
		int    n_noted;
		logic [1:0]  kind;
		logic [30:0] len_x, len_y, len_z;
		longint      org_x, org_y, org_z;
		logic [30:0] step;
		longint      offset;
		longint      stored_cnt;

		function new();
			n_errors = 0;
			n_checked = 0;
			n_noted = 0;
			reset_state();
		endfunction

		function void reset_state();
			kind = spbu_pkg::KIND_OPEN;
			len_x = 31'd1048576;
			len_y = 31'd1048576;
			len_z = 31'd1048576;
			org_x = 0;
			org_y = 0;
			org_z = 0;
			step = 0;
			offset = 0;
			stored_cnt = 0;
		endfunction

		function void write_reg(logic [spbu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
			case (idx)
				spbu_pkg::REG_KIND: kind = v[1:0];
				spbu_pkg::REG_BOX_X: len_x = v[30:0];
				spbu_pkg::REG_BOX_Y: len_y = v[30:0];
				spbu_pkg::REG_BOX_Z: len_z = v[30:0];
				spbu_pkg::REG_ORIGIN_X: org_x = longint'(signed'(v));
				spbu_pkg::REG_ORIGIN_Y: org_y = longint'(signed'(v));
				spbu_pkg::REG_ORIGIN_Z: org_z = longint'(signed'(v));
				spbu_pkg::REG_SHEAR: step = v[30:0];
				default: ;
			endcase
		endfunction

		function longint floor_div(longint n, longint d);
			longint q;
			q = n / d;
			if ((n % d) != 0 && n < 0) begin
				q--;
			end
			return q;
		endfunction

		function longint nearest(longint r, longint l);
			return floor_div(2 * r + l, 2 * l);
		endfunction

		function longint clip8(longint v);
			if (v > 127) return 127;
			if (v < -128) return -128;
			return v;
		endfunction

		function logic [31:0] clip32(longint v);
			if (v > 64'sd2147483647) v = 64'sd2147483647;
			if (v < -64'sd2147483648) v = -64'sd2147483648;
			return v[31:0];
		endfunction

		function void note_request(spbu_pkg::in_t t);
			longint ax, ay, az, bx, by, bz, lx, ly, lz;
			longint rx, ry, rz, cnt, c;
			logic [1:0] k;
			spbu_pkg::out_t e;
			ax = longint'(t.a_x); ay = longint'(t.a_y); az = longint'(t.a_z);
			bx = longint'(t.b_x); by = longint'(t.b_y); bz = longint'(t.b_z);
			lx = (len_x == 0) ? 1 : longint'(len_x);
			ly = (len_y == 0) ? 1 : longint'(len_y);
			lz = (len_z == 0) ? 1 : longint'(len_z);
			// unused kind 3 behaves as open
			k = (kind == 2'd3) ? spbu_pkg::KIND_OPEN : kind;
			rx = 0; ry = 0; rz = 0; cnt = 0;
			case (t.mode)
				spbu_pkg::MODE_DIFF: begin
					rx = bx - ax; ry = by - ay; rz = bz - az;
					if (k == spbu_pkg::KIND_PERIODIC) begin
						c = nearest(ry, ly);
						rx -= nearest(rx, lx) * lx;
						ry -= c * ly;
						rz -= nearest(rz, lz) * lz;
						cnt = clip8(c);
					end else if (k == spbu_pkg::KIND_SHEARED) begin
						// saturated count drives shift, y result and stored count
						c = clip8(nearest(ry, ly));
						rx -= offset * c;
						rx -= nearest(rx, lx) * lx;
						ry -= c * ly;
						rz -= nearest(rz, lz) * lz;
						cnt = c;
						stored_cnt = c;
					end
				end
				spbu_pkg::MODE_VEL: begin
					rx = bx - ax; ry = by - ay; rz = bz - az;
					if (k == spbu_pkg::KIND_SHEARED) begin
						rx -= ly * stored_cnt;
						cnt = stored_cnt;
					end
				end
				spbu_pkg::MODE_WRAP: begin
					rx = ax; ry = ay; rz = az;
					if (k == spbu_pkg::KIND_PERIODIC) begin
						c = floor_div(ay - org_y, ly);
						rx -= floor_div(ax - org_x, lx) * lx;
						ry -= c * ly;
						rz -= floor_div(az - org_z, lz) * lz;
						cnt = clip8(c);
					end else if (k == spbu_pkg::KIND_SHEARED) begin
						// shifted x is floored, not the raw one
						c = clip8(floor_div(ay - org_y, ly));
						rx -= offset * c;
						rx -= floor_div(rx - org_x, lx) * lx;
						ry -= c * ly;
						rz -= floor_div(az - org_z, lz) * lz;
						cnt = c;
					end
				end
				default: begin
					offset = (offset + longint'(step)) % lx;
				end
			endcase
			e.out_x = clip32(rx);
			e.out_y = clip32(ry);
			e.out_z = clip32(rz);
			e.image_shift_y = cnt[7:0];
			pending.push_back(e);
			n_noted++;
		endfunction

		function void check_result(spbu_pkg::out_t got);
			spbu_pkg::out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %h", got);
				n_errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (got.out_x !== e.out_x) begin
				$error("out_x expected %h actual %h", e.out_x, got.out_x);
				n_errors++;
			end
			if (got.out_y !== e.out_y) begin
				$error("out_y expected %h actual %h", e.out_y, got.out_y);
				n_errors++;
			end
			if (got.out_z !== e.out_z) begin
				$error("out_z expected %h actual %h", e.out_z, got.out_z);
				n_errors++;
			end
			if (got.image_shift_y !== e.image_shift_y) begin
				$error("image_shift_y expected %h actual %h", e.image_shift_y,
					got.image_shift_y);
				n_errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	spbu_pkg::in_t  in_data;
	logic out_valid;
	logic out_stall;
	spbu_pkg::out_t out_data;
	logic cfg_we;
	logic [spbu_pkg::CFG_IDX_W-1:0] cfg_addr;
	logic [spbu_pkg::FIELD_W-1:0]   cfg_wdata;

	image_scoreboard sb;
	// idling switches: random bursts on, off for the closing part
	bit   idle_enable;
	bit   hold_request;
	bit   hold_done;
	int   n_cfg;

	sheared_periodic_boundary_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
	end
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: far beyond ~400 transactions plus stalls
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Output monitor: sample at the edge, check every accepted transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(out_data);
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				out_stall <= 1'b1;
				// counted here so the block fills and stalls its input
				repeat (600) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
				hold_done = 1'b1;
				@(posedge clk);
			end else if (idle_enable && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 15);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Offer one transaction and wait for acceptance; valid stays up back to back
	task automatic send_request(spbu_pkg::in_t t);
		int n;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= t;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		sb.note_request(t);
	endtask

	task automatic drop_valid();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for the pipe to drain, then let the divider finish any tail work
	task automatic wait_drained();
		int guard;
		guard = 0;
		drop_valid();
		while (sb.pending.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [spbu_pkg::CFG_IDX_W-1:0] idx, logic [31:0] v);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, v);
		n_cfg++;
	endtask

	function automatic logic [31:0] rand32();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = 32'h7fffffff;
			1: v = 32'h80000000;
			2: v = $urandom_range(0, 4) - 2;
			3: v = $urandom_range(0, 32'h0007ffff) - 32'h00040000;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_len();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'h7fffffff;
			2: return $urandom_range(1, 16);
			3: return $urandom();
			default: return $urandom_range(32'h00008000, 32'h00400000);
		endcase
	endfunction

	function automatic spbu_pkg::in_t make_request(logic [1:0] m);
		spbu_pkg::in_t t;
		t.mode = m;
		t.a_x = rand32(); t.a_y = rand32(); t.a_z = rand32();
		t.b_x = rand32(); t.b_y = rand32(); t.b_z = rand32();
		return t;
	endfunction

	// Full register set; small boxes most often so counts and wraps are live
	task automatic random_config(logic [1:0] k);
		write_reg(spbu_pkg::REG_KIND, {30'd0, k});
		write_reg(spbu_pkg::REG_BOX_X, rand_len());
		write_reg(spbu_pkg::REG_BOX_Y, rand_len());
		write_reg(spbu_pkg::REG_BOX_Z, rand_len());
		write_reg(spbu_pkg::REG_ORIGIN_X, rand32());
		write_reg(spbu_pkg::REG_ORIGIN_Y, rand32());
		write_reg(spbu_pkg::REG_ORIGIN_Z, rand32());
		write_reg(spbu_pkg::REG_SHEAR, rand_len());
	endtask

	task automatic directed_phase();
		spbu_pkg::in_t t;
		logic [1:0] m;
		// extremes in every mode, sheared kind with a tiny box to force saturation
		write_reg(spbu_pkg::REG_KIND, {30'd0, spbu_pkg::KIND_SHEARED});
		write_reg(spbu_pkg::REG_BOX_X, 32'd3);
		write_reg(spbu_pkg::REG_BOX_Y, 32'd0);
		write_reg(spbu_pkg::REG_BOX_Z, 32'h7fffffff);
		write_reg(spbu_pkg::REG_ORIGIN_X, 32'h80000000);
		write_reg(spbu_pkg::REG_ORIGIN_Y, 32'h7fffffff);
		write_reg(spbu_pkg::REG_ORIGIN_Z, 32'd0);
		write_reg(spbu_pkg::REG_SHEAR, 32'h7fffffff);
		for (int i = 0; i < 4; i++) begin
			m = i[1:0];
			t = '{mode: m, a_x: 32'h80000000, a_y: 32'h80000000, a_z: 32'h80000000,
				b_x: 32'h7fffffff, b_y: 32'h7fffffff, b_z: 32'h7fffffff};
			send_request(t);
			t = '{mode: m, a_x: 32'h7fffffff, a_y: 32'h7fffffff, a_z: 32'h7fffffff,
				b_x: 32'h80000000, b_y: 32'h80000000, b_z: 32'h80000000};
			send_request(t);
			t = '{mode: m, a_x: 32'hffffffff, a_y: 32'h0, a_z: 32'h1,
				b_x: 32'h0, b_y: 32'hffffffff, b_z: 32'h0};
			send_request(t);
		end
		// tick once more, then sheared difference and velocity use the new offset
		send_request(make_request(spbu_pkg::MODE_TICK));
		send_request(make_request(spbu_pkg::MODE_DIFF));
		send_request(make_request(spbu_pkg::MODE_VEL));
		wait_drained();
		// unused kind 3 acts as open, shrinking box_x reduces offset on next tick
		write_reg(spbu_pkg::REG_KIND, 32'd3);
		write_reg(spbu_pkg::REG_BOX_X, 32'd1);
		for (int i = 0; i < 4; i++) begin
			send_request(make_request(i[1:0]));
		end
		wait_drained();
	endtask

	initial begin : stimulus
		int   pick;
		int   n_phase;
		logic [1:0] k;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		idle_enable = 1'b1;
		hold_request = 1'b0;
		hold_done = 1'b0;
		n_cfg = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults first: open kind after reset
		for (int i = 0; i < 4; i++) begin
			send_request(make_request(i[1:0]));
		end
		wait_drained();
		directed_phase();

		for (n_phase = 0; n_phase < 16; n_phase++) begin
			k = (n_phase < 3) ? n_phase[1:0] : 2'($urandom_range(0, 3));
			if (n_phase == 15) begin
				idle_enable = 1'b0;
			end
			random_config(k);
			if (n_phase == 5) begin
				hold_request = 1'b1;
			end
			for (int i = 0; i < 17; i++) begin
				// mostly diff followed by velocity, so the stored count is exercised
				pick = $urandom_range(0, 9);
				if (pick < 4) begin
					send_request(make_request(spbu_pkg::MODE_DIFF));
					send_request(make_request(spbu_pkg::MODE_VEL));
				end else if (pick < 7) begin
					send_request(make_request(spbu_pkg::MODE_WRAP));
				end else begin
					send_request(make_request(2'($urandom_range(0, 3))));
				end
			end
			wait_drained();
		end

		repeat (300) @(posedge clk);
		$display("Run covered %0d transactions in all boundary kinds and modes,",
			sb.n_checked);
		$display("%0d register writes, long output hold-off done: %0d",
			n_cfg, hold_done);
		if (sb.n_errors == 0 && sb.pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
